// ===== design/sswq_pkg.sv =====
// sswq_pkg: shared types and codes of the sorted sleep/wake-up queue
// depends on nothing; used by the cell, the top level and the checker
`default_nettype none
package sswq_pkg;

	localparam int TICK_W = 63;

	typedef enum logic [1:0] {
		KIND_ACCEPT = 2'd0,
		KIND_REJECT = 2'd1,
		KIND_WOKEN  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INSERT,
		ST_DRAIN
	} state_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_POP
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t           cmd;
		logic [TICK_W-1:0]   new_wake;
	} cell_ctrl_t;

endpackage
`default_nettype wire

// ===== design/sswq_cell.sv =====
// sswq_cell: one slot of the sorted queue chain, holds a wake-up tick and a thread id
// depends on sswq_pkg; instantiated in a row by sorted_sleep_wakeup_queue_top
`default_nettype none
module sswq_cell #(
	parameter int ID_BITS = 8
) (
	input  wire                          clk,
	input  sswq_pkg::cell_ctrl_t         ctrl,
	input  wire  [ID_BITS-1:0]           new_id,
	input  wire                          occ,
	input  wire                          prev_le,
	input  wire  [sswq_pkg::TICK_W-1:0]  prev_wake,
	input  wire  [ID_BITS-1:0]           prev_id,
	input  wire  [sswq_pkg::TICK_W-1:0]  next_wake,
	input  wire  [ID_BITS-1:0]           next_id,
	output logic [sswq_pkg::TICK_W-1:0]  wake,
	output logic [ID_BITS-1:0]           id,
	output logic                         le
);

	logic [sswq_pkg::TICK_W-1:0] wake_q;
	logic [ID_BITS-1:0]          id_q;

	// stays ahead of the new item when occupied and not later
	assign le   = occ && (wake_q <= ctrl.new_wake);
	assign wake = wake_q;
	assign id   = id_q;

	always_ff @(posedge clk) begin
		case (ctrl.cmd)
			sswq_pkg::CELL_INSERT: begin
				if (!le) begin
					if (prev_le) begin
						wake_q <= ctrl.new_wake;
						id_q   <= new_id;
					end else begin
						wake_q <= prev_wake;
						id_q   <= prev_id;
					end
				end
			end
			sswq_pkg::CELL_POP: begin
				wake_q <= next_wake;
				id_q   <= next_id;
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== design/sorted_sleep_wakeup_queue_top.sv =====
// sorted_sleep_wakeup_queue_top: tick counter plus a sorted chain of sleeper cells
// depends on sswq_pkg and sswq_cell
//
// usage:
//   slave channel takes one item: tuser = op (0 sleep request, 1 timer tick),
//   tdata = sleep_ticks and thread_id. master channel gives results: tuser = kind,
//   tlast = last, tdata = woken_id and now_tick.
//   a sleep request first forms and registers the wake-up tick, then every cell
//   compares it and shifts in parallel while the accept result is loaded into the
//   output register. a request on a full queue is rejected, its result registered
//   in the cycle after the item, and the sequencer stays idle.
//   a tick bumps the counter, then pops the head one result per cycle while it is
//   due and the output register is free; a tick that wakes nobody gives no result
//   and goes from the drain state back to idle. the drain rate is set by the
//   single output register.
//   the slave side is ready only between items and while the output register is
//   free or being taken; a stall on the master side holds the result and pauses
//   the drain. reset clears the counter, the entry count and the output valid flag.
`default_nettype none
module sorted_sleep_wakeup_queue_top #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_BITS     = 8
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [39:0] s_tdata,   // sleep_ticks[31:0], thread_id[39:32]
	input  wire  [0:0]  s_tuser,   // op[0]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [71:0] m_tdata,   // woken_id[7:0], now_tick[70:8], zero[71]
	output logic [1:0]  m_tuser,   // kind[1:0]
	output logic        m_tlast
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int TW    = sswq_pkg::TICK_W;

	sswq_pkg::state_t state_q, state_d;

	logic [TW-1:0]      tick_q;
	logic [CNT_W-1:0]   count_q;
	logic [TW-1:0]      wake_q;
	logic [ID_BITS-1:0] id_q;

	logic               out_valid_q;
	sswq_pkg::kind_t    out_kind_q;
	logic [7:0]         out_id_q;
	logic [TW-1:0]      out_tick_q;
	logic               out_last_q;

	logic               out_free;
	logic               in_acc;
	logic               full;
	logic [TW:0]        wake_sum;
	logic [TW-1:0]      wake_sat;
	logic [ID_BITS-1:0] in_id;
	logic               head_due;
	logic               next_due;

	logic               out_load;
	sswq_pkg::kind_t    out_kind_d;
	logic [7:0]         out_id_d;
	logic [TW-1:0]      out_tick_d;
	logic               out_last_d;
	logic               start_insert;
	logic               do_insert;
	logic               do_pop;
	logic               do_tick;

	sswq_pkg::cell_ctrl_t ctrl;

	logic [TW-1:0]      cell_wake [QUEUE_DEPTH];
	logic [ID_BITS-1:0] cell_id   [QUEUE_DEPTH];
	logic               cell_le   [QUEUE_DEPTH];

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == sswq_pkg::ST_IDLE) && out_free;
	assign in_acc   = s_tvalid && s_tready;
	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign in_id    = ID_BITS'(s_tdata[39:32]);
	assign wake_sum = {1'b0, tick_q} + (TW + 1)'(s_tdata[31:0]);
	assign wake_sat = wake_sum[TW] ? {TW{1'b1}} : wake_sum[TW-1:0];
	assign head_due = (count_q != '0) && (cell_wake[0] <= tick_q);
	assign next_due = (count_q > CNT_W'(1)) && (cell_wake[1] <= tick_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sswq_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (s_tuser[0])
						state_d = sswq_pkg::ST_DRAIN;
					else if (!full)
						state_d = sswq_pkg::ST_INSERT;
				end
			end
			sswq_pkg::ST_INSERT: begin
				state_d = sswq_pkg::ST_IDLE;
			end
			sswq_pkg::ST_DRAIN: begin
				if (!head_due)
					state_d = sswq_pkg::ST_IDLE;
				else if (out_free && !next_due)
					state_d = sswq_pkg::ST_IDLE;
			end
			default: state_d = sswq_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		out_load     = 1'b0;
		out_kind_d   = sswq_pkg::KIND_ACCEPT;
		out_id_d     = 8'(id_q);
		out_tick_d   = tick_q;
		out_last_d   = 1'b1;
		start_insert = 1'b0;
		do_insert    = 1'b0;
		do_pop       = 1'b0;
		do_tick      = 1'b0;
		unique case (state_q)
			sswq_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (s_tuser[0]) begin
						do_tick = 1'b1;
					end else if (full) begin
						out_load   = 1'b1;
						out_kind_d = sswq_pkg::KIND_REJECT;
						out_id_d   = 8'(in_id);
					end else begin
						start_insert = 1'b1;
					end
				end
			end
			sswq_pkg::ST_INSERT: begin
				do_insert  = 1'b1;
				out_load   = 1'b1;
				out_kind_d = sswq_pkg::KIND_ACCEPT;
			end
			sswq_pkg::ST_DRAIN: begin
				if (head_due && out_free) begin
					do_pop     = 1'b1;
					out_load   = 1'b1;
					out_kind_d = sswq_pkg::KIND_WOKEN;
					out_id_d   = 8'(cell_id[0]);
					out_last_d = !next_due;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		ctrl.new_wake = wake_q;
		if (do_insert)
			ctrl.cmd = sswq_pkg::CELL_INSERT;
		else if (do_pop)
			ctrl.cmd = sswq_pkg::CELL_POP;
		else
			ctrl.cmd = sswq_pkg::CELL_HOLD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sswq_pkg::ST_IDLE;
			tick_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_tick)
				tick_q <= tick_q + TW'(1);
			if (do_insert)
				count_q <= count_q + CNT_W'(1);
			else if (do_pop)
				count_q <= count_q - CNT_W'(1);
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start_insert) begin
			wake_q <= wake_sat;
			id_q   <= in_id;
		end
		if (out_load) begin
			out_kind_q <= out_kind_d;
			out_id_q   <= out_id_d;
			out_tick_q <= out_tick_d;
			out_last_q <= out_last_d;
		end
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic               occ;
		logic               prev_le;
		logic [TW-1:0]      prev_wake;
		logic [ID_BITS-1:0] prev_id;
		logic [TW-1:0]      next_wake;
		logic [ID_BITS-1:0] next_id;

		assign occ = (count_q > CNT_W'(i));

		if (i == 0) begin : g_head
			assign prev_le   = 1'b1;
			assign prev_wake = wake_q;
			assign prev_id   = id_q;
		end else begin : g_body
			assign prev_le   = cell_le[i-1];
			assign prev_wake = cell_wake[i-1];
			assign prev_id   = cell_id[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign next_wake = '0;
			assign next_id   = '0;
		end else begin : g_inner
			assign next_wake = cell_wake[i+1];
			assign next_id   = cell_id[i+1];
		end

		sswq_cell #(
			.ID_BITS (ID_BITS)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.new_id    (id_q),
			.occ       (occ),
			.prev_le   (prev_le),
			.prev_wake (prev_wake),
			.prev_id   (prev_id),
			.next_wake (next_wake),
			.next_id   (next_id),
			.wake      (cell_wake[i]),
			.id        (cell_id[i]),
			.le        (cell_le[i])
		);
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_tick_q, out_id_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

endmodule
`default_nettype wire

// ===== design/sswq_checker.sv =====
// sswq_checker: port-level checks of the sorted sleep/wake-up queue over time
// depends on sswq_pkg; bound to sorted_sleep_wakeup_queue_top
`default_nettype none
module sswq_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tready,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [71:0] m_tdata,
	input wire [1:0]  m_tuser,
	input wire        m_tlast
);

	// stalled item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
		&& $stable(m_tlast))
		else $error("stalled result changed");

	// sleep answers are single-item bursts
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == sswq_pkg::KIND_ACCEPT || m_tuser == sswq_pkg::KIND_REJECT)
		|-> m_tlast)
		else $error("sleep answer without last");

	// no new item while a wake burst is open
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input taken inside a wake burst");

	// wakes of one burst share the tick
	a_tick: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> !m_tvalid
		|| (m_tdata[70:8] == $past(m_tdata[70:8])))
		else $error("tick changed inside a wake burst");

endmodule

bind sorted_sleep_wakeup_queue_top sswq_checker u_sswq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
`default_nettype wire

// ===== sim/tb_sorted_sleep_wakeup_queue_top.sv =====
// tb_sorted_sleep_wakeup_queue_top: self-checking bench for the sorted sleep/wake-up queue
// keeps its own sorted sleeper list and tick counter and checks every result item in order
// depends on sswq_pkg and sorted_sleep_wakeup_queue_top
`default_nettype none
module tb_sorted_sleep_wakeup_queue_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUEUE_DEPTH    = 16;
	localparam int ID_BITS        = 8;
	localparam bit OP_SLEEP       = 1'b0;
	localparam bit OP_TICK        = 1'b1;
	localparam int HOLD_CYCLES    = 80;
	localparam int SETTLE_CYCLES  = 2 * QUEUE_DEPTH + 4;
	localparam int WATCHDOG_LIMIT = 1000;

	typedef struct {
		sswq_pkg::kind_t             kind;
		logic [7:0]                  id;
		logic [sswq_pkg::TICK_W-1:0] now;
		logic                        last;
	} reply_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata  = '0;  // sleep_ticks[31:0], thread_id[39:32]
	logic [0:0]  s_tuser  = '0;  // op[0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;        // woken_id[7:0], now_tick[70:8], zero[71]
	logic [1:0]  m_tuser;        // kind[1:0]
	logic        m_tlast;

	reply_t                      pending_replies[$];
	logic [sswq_pkg::TICK_W-1:0] tick_now = '0;
	logic [sswq_pkg::TICK_W-1:0] wake_at[QUEUE_DEPTH];
	logic [7:0]                  owner_at[QUEUE_DEPTH];
	int                sleeper_cnt = 0;
	int                mismatches  = 0;
	logic              idle_on     = 1'b1;
	logic              hold_token  = 1'b0;
	logic              hold_seen   = 1'b0;
	int                hold_left   = 0;
	int                quiet_cycles = 0;

	sorted_sleep_wakeup_queue_top #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.ID_BITS    (ID_BITS)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic reply_t reply(input sswq_pkg::kind_t kind, input logic [7:0] id,
		input logic last);
		reply_t r;
		r.kind = kind;
		r.id   = id;
		r.now  = tick_now;
		r.last = last;
		return r;
	endfunction

	// sorted insert or reject on a full list on sleep, bump and pop due sleepers on tick
	function automatic void apply_to_sleep_queue(input logic op, input logic [31:0] span,
		input logic [7:0] id);
		logic [63:0]                 sum;
		logic [sswq_pkg::TICK_W-1:0] wake;
		int                          pos;
		int                          popped;
		if (op == OP_SLEEP) begin
			if (sleeper_cnt >= QUEUE_DEPTH) begin
				pending_replies.push_back(reply(sswq_pkg::KIND_REJECT, id, 1'b1));
				return;
			end
			sum  = {1'b0, tick_now} + {32'd0, span};
			wake = sum[63] ? {sswq_pkg::TICK_W{1'b1}} : sum[sswq_pkg::TICK_W-1:0];
			pos  = 0;
			while (pos < sleeper_cnt && wake_at[pos] <= wake)
				pos++;
			for (int j = sleeper_cnt; j > pos; j--) begin
				wake_at[j]  = wake_at[j-1];
				owner_at[j] = owner_at[j-1];
			end
			wake_at[pos]  = wake;
			owner_at[pos] = id;
			sleeper_cnt++;
			pending_replies.push_back(reply(sswq_pkg::KIND_ACCEPT, id, 1'b1));
		end else begin
			tick_now = tick_now + 1'b1;
			popped   = 0;
			while (popped < sleeper_cnt && wake_at[popped] <= tick_now) begin
				pending_replies.push_back(reply(sswq_pkg::KIND_WOKEN, owner_at[popped], 1'b0));
				popped++;
			end
			if (popped == 0)
				return;
			pending_replies[pending_replies.size()-1].last = 1'b1;
			for (int j = popped; j < sleeper_cnt; j++) begin
				wake_at[j-popped]  = wake_at[j];
				owner_at[j-popped] = owner_at[j];
			end
			sleeper_cnt -= popped;
		end
	endfunction

	task automatic send_item(input logic op, input logic [31:0] span, input logic [7:0] id);
		while (idle_on && $urandom_range(0, 99) < 35) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {id, span};
		s_tuser  <= op;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		apply_to_sleep_queue(op, span, id);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_seen != hold_token) begin
			hold_seen <= hold_token;
			hold_left <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= !(idle_on && $urandom_range(0, 99) < 35);
		end
	end

	always @(posedge clk) begin : check_replies
		reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_replies.size() == 0) begin
				$display("%0t: unexpected item kind %0d id %0d", $time, m_tuser, m_tdata[7:0]);
				mismatches++;
			end else begin
				want = pending_replies.pop_front();
				if (m_tuser !== want.kind) begin
					$display("%0t: kind expected %0d got %0d", $time, want.kind, m_tuser);
					mismatches++;
				end
				if (m_tdata[7:0] !== want.id) begin
					$display("%0t: woken_id expected %0d got %0d", $time, want.id, m_tdata[7:0]);
					mismatches++;
				end
				if (m_tdata[70:8] !== want.now) begin
					$display("%0t: now_tick expected %0d got %0d", $time, want.now, m_tdata[70:8]);
					mismatches++;
				end
				if (m_tlast !== want.last) begin
					$display("%0t: last expected %0d got %0d", $time, want.last, m_tlast);
					mismatches++;
				end
			end
		end
	end

	initial begin : watchdog
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("TEST FAILED");
		$finish;
	end

	task automatic test_empty_tick();
		send_item(OP_TICK, 32'($urandom), 8'($urandom));
	endtask

	task automatic test_zero_and_long_sleep();
		send_item(OP_SLEEP, 32'd0, 8'h00);
		send_item(OP_SLEEP, 32'hFFFF_FFFF, 8'hFF);
		send_item(OP_TICK, '0, '0);
	endtask

	task automatic test_equal_wake_order();
		send_item(OP_SLEEP, 32'd3, 8'h11);
		send_item(OP_SLEEP, 32'd3, 8'h22);
		send_item(OP_SLEEP, 32'd3, 8'h33);
		send_item(OP_SLEEP, 32'd2, 8'h44);
		send_item(OP_SLEEP, 32'd3, 8'h55);
		repeat (3)
			send_item(OP_TICK, '0, '0);
	endtask

	// receiver stalls long at first, then the queue is offered more sleepers than its depth
	task automatic test_backpressure_full_queue();
		hold_token <= ~hold_token;
		@(posedge clk);
		for (int n = 0; n < QUEUE_DEPTH + 2; n++)
			send_item(OP_SLEEP, 32'($urandom_range(1, 3)), 8'($urandom));
		repeat (4)
			send_item(OP_TICK, 32'($urandom), 8'($urandom));
	endtask

	task automatic test_random_traffic(input int n_items);
		int          sleep_pct;
		logic [31:0] span;
		sleep_pct = 50;
		for (int n = 0; n < n_items; n++) begin
			if (n % 20 == 0) begin
				case ($urandom_range(0, 2))
					0: sleep_pct = 25;
					1: sleep_pct = 55;
					default: sleep_pct = 90;
				endcase
			end
			if ($urandom_range(0, 99) < sleep_pct) begin
				span = ($urandom_range(0, 4) == 0) ? 32'($urandom_range(7, 40))
				                                   : 32'($urandom_range(0, 6));
				send_item(OP_SLEEP, span, 8'($urandom));
			end else begin
				send_item(OP_TICK, 32'($urandom), 8'($urandom));
			end
		end
	endtask

	initial begin
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_tick();
		test_zero_and_long_sleep();
		test_equal_wake_order();
		test_backpressure_full_queue();
		test_random_traffic(80);
		idle_on <= 1'b0;
		test_random_traffic(60);
		idle_on <= 1'b1;
		test_random_traffic(100);
		s_tvalid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
`default_nettype wire

// ===== files.f =====
design/sswq_pkg.sv
design/sswq_cell.sv
design/sorted_sleep_wakeup_queue_top.sv
design/sswq_checker.sv
sim/tb_sorted_sleep_wakeup_queue_top.sv
